### sv/bmfo_pkg.sv
package bmfo_pkg;

  localparam int NUM_BANKS  = 5;
  localparam int FIFO_DEPTH = 10;
  localparam int TAG_BITS   = 64;
  localparam int CAPACITY   = (NUM_BANKS + 1) * FIFO_DEPTH;

  // Fixed field widths of the request and result items
  localparam int TAG_FIELD_W = 64;
  localparam int OCC_FIELD_W = 6;

  localparam int BANK_W  = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
  localparam int PTR_W   = $clog2(FIFO_DEPTH);
  localparam int CNT_W   = $clog2(FIFO_DEPTH + 1);
  localparam int SUM_W   = CNT_W + 1;
  localparam int OCC_W   = $clog2(CAPACITY + 1);
  localparam int BADDR_W = $clog2(NUM_BANKS * FIFO_DEPTH);

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  typedef struct packed {
    logic                   req_type;
    logic [TAG_FIELD_W-1:0] tag_in;
  } req_t;

  typedef struct packed {
    logic                   accepted;
    logic [TAG_FIELD_W-1:0] tag_out;
    logic [OCC_FIELD_W-1:0] occupancy;
    logic                   now_empty;
    logic                   now_full;
  } rsp_t;

  // Controller commands to the datapath
  typedef struct packed {
    logic ins;   // execute an insert from the request on the port
    logic rd;    // start a remove: pick the bank, launch the store reads
    logic fin;   // finish a remove: pop, refill, post the result
  } cmd_t;

  // Fold a pointer sum (below twice the depth) back into the ring
  function automatic logic [PTR_W-1:0] wrap_ptr(input logic [SUM_W-1:0] s);
    logic [SUM_W-1:0] d;
    d = s - SUM_W'(FIFO_DEPTH);
    if (s >= SUM_W'(FIFO_DEPTH)) begin
      return d[PTR_W-1:0];
    end
    return s[PTR_W-1:0];
  endfunction

  function automatic logic [BADDR_W-1:0] bank_addr(input logic [BANK_W-1:0] bank,
                                                   input logic [PTR_W-1:0] ptr);
    logic [BADDR_W-1:0] base;
    base = BADDR_W'(BADDR_W'(bank) * BADDR_W'(FIFO_DEPTH));
    return BADDR_W'(base + BADDR_W'(ptr));
  endfunction

endpackage

### sv/bmfo_ram.sv
module bmfo_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### sv/bmfo_ctrl.sv
module bmfo_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          req_type,
  output logic          out_valid,
  input  logic          out_ready,
  output bmfo_pkg::cmd_t cmd
);
  import bmfo_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_POP
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_fire;

  assign in_ready = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    cmd.ins = in_fire && (req_type == REQ_INSERT);
    cmd.rd  = in_fire && (req_type == REQ_REMOVE);
    cmd.fin = (state_r == ST_POP);

    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd.rd) begin
          state_nxt = ST_POP;
        end
      end
      ST_POP: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.ins || cmd.fin) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

### sv/bmfo_dp.sv
module bmfo_dp (
  input  logic           clk,
  input  logic           rst_n,
  input  bmfo_pkg::cmd_t cmd,
  input  bmfo_pkg::req_t in_data,
  output bmfo_pkg::rsp_t out_data
);
  import bmfo_pkg::*;

  logic [PTR_W-1:0]  bank_head_r  [NUM_BANKS];
  logic [PTR_W-1:0]  bank_head_nxt[NUM_BANKS];
  logic [CNT_W-1:0]  bank_count_r  [NUM_BANKS];
  logic [CNT_W-1:0]  bank_count_nxt[NUM_BANKS];
  logic [PTR_W-1:0]  ovf_head_r, ovf_head_nxt;
  logic [CNT_W-1:0]  ovf_count_r, ovf_count_nxt;
  logic [OCC_W-1:0]  occ_r, occ_nxt;

  logic [BANK_W-1:0] sel_r, sel_nxt;
  logic              any_bank_r, any_bank_nxt;
  logic              pop_ok_r, pop_ok_nxt;
  rsp_t              rsp_r, rsp_nxt;

  logic [BANK_W-1:0] best;
  logic [BANK_W-1:0] first;
  logic              any_bank;
  logic [PTR_W-1:0]  tail;

  logic               bram_we, oram_we;
  logic [BADDR_W-1:0] bram_waddr, bram_raddr;
  logic [PTR_W-1:0]   oram_waddr;
  logic [TAG_BITS-1:0] bram_wdata, oram_wdata;
  logic [TAG_BITS-1:0] bram_rdata, oram_rdata;
  logic [TAG_BITS-1:0] popped;

  bmfo_ram #(.WIDTH(TAG_BITS), .DEPTH(NUM_BANKS * FIFO_DEPTH)) u_bank_ram (
    .clk   (clk),
    .we    (bram_we),
    .waddr (bram_waddr),
    .wdata (bram_wdata),
    .re    (cmd.rd),
    .raddr (bram_raddr),
    .rdata (bram_rdata)
  );

  bmfo_ram #(.WIDTH(TAG_BITS), .DEPTH(FIFO_DEPTH)) u_ovf_ram (
    .clk   (clk),
    .we    (oram_we),
    .waddr (oram_waddr),
    .wdata (oram_wdata),
    .re    (cmd.rd),
    .raddr (ovf_head_r),
    .rdata (oram_rdata)
  );

  // Least-occupied bank, lowest index on ties
  always_comb begin
    best = '0;
    for (int b = 1; b < NUM_BANKS; b++) begin
      if (bank_count_r[b] < bank_count_r[best]) begin
        best = BANK_W'(b);
      end
    end
  end

  // Lowest-indexed non-empty bank
  always_comb begin
    first    = '0;
    any_bank = 1'b0;
    for (int b = NUM_BANKS - 1; b >= 0; b--) begin
      if (bank_count_r[b] != '0) begin
        first    = BANK_W'(b);
        any_bank = 1'b1;
      end
    end
  end

  assign bram_raddr = bank_addr(first, bank_head_r[first]);
  assign popped     = any_bank_r ? bram_rdata : oram_rdata;
  assign tail       = wrap_ptr(SUM_W'(bank_head_r[sel_r]) + SUM_W'(bank_count_r[sel_r]));

  always_comb begin
    bank_head_nxt  = bank_head_r;
    bank_count_nxt = bank_count_r;
    ovf_head_nxt   = ovf_head_r;
    ovf_count_nxt  = ovf_count_r;
    occ_nxt        = occ_r;
    sel_nxt        = sel_r;
    any_bank_nxt   = any_bank_r;
    pop_ok_nxt     = pop_ok_r;
    rsp_nxt        = rsp_r;

    bram_we    = 1'b0;
    bram_waddr = '0;
    bram_wdata = oram_rdata;
    oram_we    = 1'b0;
    oram_waddr = wrap_ptr(SUM_W'(ovf_head_r) + SUM_W'(ovf_count_r));
    oram_wdata = in_data.tag_in[TAG_BITS-1:0];

    if (cmd.ins) begin
      if (occ_r != OCC_W'(CAPACITY)) begin
        if (bank_count_r[best] < CNT_W'(FIFO_DEPTH)) begin
          bram_we    = 1'b1;
          bram_waddr = bank_addr(best, wrap_ptr(SUM_W'(bank_head_r[best]) +
                                                SUM_W'(bank_count_r[best])));
          bram_wdata = in_data.tag_in[TAG_BITS-1:0];
          bank_count_nxt[best] = CNT_W'(bank_count_r[best] + CNT_W'(1));
        end else begin
          oram_we       = 1'b1;
          ovf_count_nxt = CNT_W'(ovf_count_r + CNT_W'(1));
        end
        occ_nxt = OCC_W'(occ_r + OCC_W'(1));
      end
      rsp_nxt.accepted  = (occ_r != OCC_W'(CAPACITY));
      rsp_nxt.tag_out   = '0;
      rsp_nxt.occupancy = OCC_FIELD_W'(occ_nxt);
      rsp_nxt.now_empty = (occ_nxt == '0);
      rsp_nxt.now_full  = (occ_nxt == OCC_W'(CAPACITY));
    end

    if (cmd.rd) begin
      sel_nxt      = first;
      any_bank_nxt = any_bank;
      pop_ok_nxt   = (occ_r != '0);
    end

    if (cmd.fin) begin
      if (pop_ok_r) begin
        if (any_bank_r) begin
          bank_head_nxt[sel_r] = wrap_ptr(SUM_W'(bank_head_r[sel_r]) + SUM_W'(1));
          if (ovf_count_r != '0) begin
            // Refill: the slot freed by the pop takes the overflow head
            bram_we       = 1'b1;
            bram_waddr    = bank_addr(sel_r, tail);
            ovf_head_nxt  = wrap_ptr(SUM_W'(ovf_head_r) + SUM_W'(1));
            ovf_count_nxt = CNT_W'(ovf_count_r - CNT_W'(1));
          end else begin
            bank_count_nxt[sel_r] = CNT_W'(bank_count_r[sel_r] - CNT_W'(1));
          end
        end else begin
          ovf_head_nxt  = wrap_ptr(SUM_W'(ovf_head_r) + SUM_W'(1));
          ovf_count_nxt = CNT_W'(ovf_count_r - CNT_W'(1));
        end
        occ_nxt = OCC_W'(occ_r - OCC_W'(1));
      end
      rsp_nxt.accepted  = pop_ok_r;
      rsp_nxt.tag_out   = pop_ok_r ? TAG_FIELD_W'(popped) : '0;
      rsp_nxt.occupancy = OCC_FIELD_W'(occ_nxt);
      rsp_nxt.now_empty = (occ_nxt == '0);
      rsp_nxt.now_full  = (occ_nxt == OCC_W'(CAPACITY));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int b = 0; b < NUM_BANKS; b++) begin
        bank_head_r[b]  <= '0;
        bank_count_r[b] <= '0;
      end
      ovf_head_r  <= '0;
      ovf_count_r <= '0;
      occ_r       <= '0;
    end else begin
      bank_head_r  <= bank_head_nxt;
      bank_count_r <= bank_count_nxt;
      ovf_head_r   <= ovf_head_nxt;
      ovf_count_r  <= ovf_count_nxt;
      occ_r        <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sel_r      <= sel_nxt;
    any_bank_r <= any_bank_nxt;
    pop_ok_r   <= pop_ok_nxt;
    rsp_r      <= rsp_nxt;
  end

  assign out_data = rsp_r;

endmodule

### sv/balanced_multi_fifo_with_overflow_core.sv
// Balanced tag store: five circular FIFOs of ten 64-bit tags plus one overflow
// FIFO of ten. An insert request goes to the least-occupied bank FIFO (lowest
// index on ties), or to the overflow FIFO once every bank is full; it is refused
// when all 60 slots are taken. A remove request pops the head of the
// lowest-indexed non-empty bank and refills that bank's tail from the overflow
// head; it is refused when nothing is held. Every request yields one response
// with the accepted flag, the popped tag (zero unless a remove succeeds), the
// occupancy after the request and empty/full flags. An insert needs no second
// state; a remove goes through ST_POP, since the popped tag and the overflow head
// come out of registered-read tag RAMs in the cycle after the bank is chosen. A
// new request is taken while the previous response waits in the output register,
// as long as that register frees up at the same edge.
module balanced_multi_fifo_with_overflow_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  bmfo_pkg::req_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output bmfo_pkg::rsp_t out_data
);
  import bmfo_pkg::*;

  cmd_t cmd;

  // Handshakes and sequencing of insert and two-step remove
  bmfo_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .req_type  (in_data.req_type),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // Pointers, counts, tag RAMs and the response register
  bmfo_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule

### test/balanced_multi_fifo_with_overflow_core_tb.sv
`timescale 1ns / 1ps

module balanced_multi_fifo_with_overflow_core_tb;
  import bmfo_pkg::*;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  req_t in_data;
  logic out_valid;
  logic out_ready;
  rsp_t out_data;

  balanced_multi_fifo_with_overflow_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // Free-running clock, 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the tag store: bank rings, overflow ring, fill levels
  logic [TAG_BITS-1:0] bank_tags [NUM_BANKS][FIFO_DEPTH];
  logic [TAG_BITS-1:0] spill_tags [FIFO_DEPTH];
  int bank_head [NUM_BANKS];
  int bank_fill [NUM_BANKS];
  int spill_head;
  int spill_fill;

  // Responses owed by the block, oldest first
  rsp_t replies_due[$];

  // Idle and stall rates of the current phase, in percent
  int idle_pct;
  int stall_pct;

  int mismatch_count;
  int n_requests;
  int n_inserted;
  int n_removed;
  int n_refused;
  int n_spilled;
  int n_refilled;
  int n_full_hits;

  function automatic int tags_held();
    int sum;
    sum = spill_fill;
    for (int b = 0; b < NUM_BANKS; b++) sum += bank_fill[b];
    return sum;
  endfunction

  // Apply one request to the shadow store and return the response it must produce
  function automatic rsp_t apply_to_tag_store(req_t r);
    rsp_t rsp;
    logic [TAG_BITS-1:0] tag;
    logic [TAG_BITS-1:0] popped;
    int total;
    int pick;
    int slot;
    bit done;
    rsp = '0;
    popped = '0;
    done = 1'b0;
    tag = r.tag_in[TAG_BITS-1:0];
    total = tags_held();
    if (r.req_type == REQ_INSERT) begin
      if (total < CAPACITY) begin
        // least-occupied bank wins, lowest index on ties
        pick = 0;
        for (int b = 1; b < NUM_BANKS; b++) begin
          if (bank_fill[b] < bank_fill[pick]) pick = b;
        end
        if (bank_fill[pick] < FIFO_DEPTH) begin
          slot = (bank_head[pick] + bank_fill[pick]) % FIFO_DEPTH;
          bank_tags[pick][slot] = tag;
          bank_fill[pick]++;
        end else begin
          // every bank full: spill into the overflow ring
          slot = (spill_head + spill_fill) % FIFO_DEPTH;
          spill_tags[slot] = tag;
          spill_fill++;
          n_spilled++;
        end
        rsp.accepted = 1'b1;
        n_inserted++;
      end else begin
        n_refused++;
      end
    end else begin
      if (total > 0) begin
        for (int b = 0; b < NUM_BANKS && !done; b++) begin
          if (bank_fill[b] > 0) begin
            popped = bank_tags[b][bank_head[b]];
            bank_head[b] = (bank_head[b] + 1) % FIFO_DEPTH;
            bank_fill[b]--;
            // refill the same bank's tail from the overflow head
            if (spill_fill > 0) begin
              slot = (bank_head[b] + bank_fill[b]) % FIFO_DEPTH;
              bank_tags[b][slot] = spill_tags[spill_head];
              bank_fill[b]++;
              spill_head = (spill_head + 1) % FIFO_DEPTH;
              spill_fill--;
              n_refilled++;
            end
            done = 1'b1;
          end
        end
        if (!done) begin
          // banks empty while overflow holds tags: pop overflow directly
          popped = spill_tags[spill_head];
          spill_head = (spill_head + 1) % FIFO_DEPTH;
          spill_fill--;
        end
        rsp.accepted = 1'b1;
        n_removed++;
      end else begin
        n_refused++;
      end
    end
    total = tags_held();
    rsp.tag_out   = TAG_FIELD_W'(popped);
    rsp.occupancy = OCC_FIELD_W'(total);
    rsp.now_empty = (total == 0);
    rsp.now_full  = (total == CAPACITY);
    if (rsp.now_full) n_full_hits++;
    return rsp;
  endfunction

  function automatic logic [TAG_FIELD_W-1:0] random_tag();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  function automatic req_t make_request(logic kind, logic [TAG_FIELD_W-1:0] tag);
    req_t r;
    r.req_type = kind;
    r.tag_in   = tag;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    if (mismatch_count < 30) begin
      $display("[%0t] MISMATCH %s: got %h, expected %h", $time, what, got, want);
    end
    mismatch_count++;
  endtask

  // Send one request: idle at random first, hold valid until accepted,
  // then record the response it owes. Drive on the falling edge only.
  task automatic send_request(req_t r);
    while ($urandom_range(0, 99) < idle_pct) begin
      @(negedge clk);
      in_valid = 1'b0;
      in_data  = make_request(1'($urandom()), {$urandom(), $urandom()});
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_data  = r;
    do @(posedge clk); while (!in_ready);
    replies_due.push_back(apply_to_tag_store(r));
    n_requests++;
  endtask

  // Drop valid and hold off until every owed response has come back,
  // then let a remove still in flight settle
  task automatic wait_replies_drained();
    int guard;
    guard = 0;
    @(negedge clk);
    in_valid = 1'b0;
    while (replies_due.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (4) @(posedge clk);
  endtask

  // Receiver: stall at the phase's rate, decided on each falling edge
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Check each response against the oldest owed one, field by field
  always @(posedge clk) begin
    rsp_t want;
    if (rst_n && out_valid && out_ready) begin
      if (replies_due.size() == 0) begin
        report_mismatch("unexpected response", out_data.tag_out, '0);
      end else begin
        want = replies_due.pop_front();
        if (out_data.accepted !== want.accepted)
          report_mismatch("accepted", 64'(out_data.accepted), 64'(want.accepted));
        if (out_data.tag_out !== want.tag_out)
          report_mismatch("tag_out", out_data.tag_out, want.tag_out);
        if (out_data.occupancy !== want.occupancy)
          report_mismatch("occupancy", 64'(out_data.occupancy), 64'(want.occupancy));
        if (out_data.now_empty !== want.now_empty)
          report_mismatch("now_empty", 64'(out_data.now_empty), 64'(want.now_empty));
        if (out_data.now_full !== want.now_full)
          report_mismatch("now_full", 64'(out_data.now_full), 64'(want.now_full));
      end
    end
  end

  // Refused remove on an empty store, extreme tags spread across the banks,
  // then drain past empty so the last remove is refused again
  task automatic test_empty_and_extremes();
    send_request(make_request(REQ_REMOVE, '1));
    send_request(make_request(REQ_INSERT, '0));
    send_request(make_request(REQ_INSERT, '1));
    send_request(make_request(REQ_INSERT, 64'h5555_5555_5555_5555));
    send_request(make_request(REQ_INSERT, 64'hAAAA_AAAA_AAAA_AAAA));
    send_request(make_request(REQ_INSERT, 64'h8000_0000_0000_0001));
    send_request(make_request(REQ_INSERT, 64'h0123_4567_89AB_CDEF));
    repeat (7) send_request(make_request(REQ_REMOVE, random_tag()));
  endtask

  // Fill every bank and the overflow ring, push past full, swap one tag
  // at full so a refill happens, then drain past empty
  task automatic test_fill_and_drain();
    repeat (CAPACITY + 2) send_request(make_request(REQ_INSERT, random_tag()));
    send_request(make_request(REQ_REMOVE, random_tag()));
    send_request(make_request(REQ_INSERT, random_tag()));
    repeat (CAPACITY + 2) send_request(make_request(REQ_REMOVE, random_tag()));
  endtask

  // Random mix in runs biased toward insert or remove, so the fill level
  // wanders between empty and full
  task automatic test_random_traffic(int n_req);
    int insert_pct;
    int run_left;
    insert_pct = 50;
    run_left = 0;
    for (int i = 0; i < n_req; i++) begin
      if (run_left == 0) begin
        run_left = $urandom_range(5, 60);
        case ($urandom_range(0, 2))
          0:       insert_pct = 15;
          1:       insert_pct = 50;
          default: insert_pct = 85;
        endcase
      end
      run_left--;
      send_request(make_request(($urandom_range(0, 99) < insert_pct) ? REQ_INSERT : REQ_REMOVE,
                                random_tag()));
    end
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    mismatch_count = 0;
    n_requests = 0;
    n_inserted = 0;
    n_removed = 0;
    n_refused = 0;
    n_spilled = 0;
    n_refilled = 0;
    n_full_hits = 0;
    spill_head = 0;
    spill_fill = 0;
    for (int b = 0; b < NUM_BANKS; b++) begin
      bank_head[b] = 0;
      bank_fill[b] = 0;
    end

    // hold reset, then release it on a falling edge
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_empty_and_extremes();
    wait_replies_drained();

    // Phases: no idling, sender idle, receiver stalling, both
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 76; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 76; end
        default: begin idle_pct = 24; stall_pct = 24; end
      endcase
      test_fill_and_drain();
      wait_replies_drained();
      test_random_traffic(370);
      wait_replies_drained();
    end

    idle_pct = 0;
    stall_pct = 0;
    wait_replies_drained();
    if (replies_due.size() != 0) begin
      report_mismatch("responses never returned", 64'(replies_due.size()), '0);
    end

    $display("Covered %0d requests: %0d inserts, %0d removes, %0d refused.",
             n_requests, n_inserted, n_removed, n_refused);
    $display("Overflow spills %0d, refills %0d, full reached %0d times, %0d mismatches.",
             n_spilled, n_refilled, n_full_hits, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run
  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

### files.f
sv/bmfo_pkg.sv
sv/bmfo_ram.sv
sv/bmfo_ctrl.sv
sv/bmfo_dp.sv
sv/balanced_multi_fifo_with_overflow_core.sv
test/balanced_multi_fifo_with_overflow_core_tb.sv
